// ===== src/ffca_pkg.sv =====
// Package for the first-fit coalescing allocator core.
// Holds opcode, status and register codes; no dependencies.
package ffca_pkg;
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_NOHEAP = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_REJECT = 2'd3;

    localparam logic [0:0] REG_HEAP_LIMIT = 1'b0;
endpackage

// ===== src/first_fit_coalescing_allocator_core.sv =====
// First-fit coalescing heap allocator, top level.
// Depends on ffca_pkg.
//
// One request at a time. An allocate scans the used table for a free slot
// (one entry a cycle), then scans the free segment table first-fit (S_FRD
// issues the read of an entry, S_FCHK checks its data), then updates it: a
// split rewrites the segment in place, an exact or whole take removes the
// segment by shifting the rest down (S_SHDN reads the next entry, S_SHDN2
// writes it). If no segment fits, it grows the heap top instead. A release
// scans the used table for the address (S_USCAN reads an occupied entry,
// S_URD compares it), scans the free table for the insert point and then
// merges, or shifts entries up (S_SHUP reads, S_SHUP2 writes) to open a
// slot. The tables have one read port each with registered data. The
// result beat is held in an output register; a new request is taken once
// that beat has been accepted and the engine is back in idle.
module first_fit_coalescing_allocator_core #(
    parameter int HEAP_BYTES   = 65536,
    parameter int HEADER_BYTES = 16,
    parameter int FREE_SLOTS   = 32,
    parameter int USED_SLOTS   = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // request_size[15:0], address[31:16]
    input  logic        s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // status[1:0], result_address[17:2],
                                        // granted_size[33:18], zero pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int FW = $clog2(FREE_SLOTS);
    localparam int UW = $clog2(USED_SLOTS);
    localparam logic [16:0] HDR = 17'(HEADER_BYTES);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_USCAN = 4'd1;  // used table scan
    localparam logic [3:0] S_FRD   = 4'd2;  // free table read issue
    localparam logic [3:0] S_FCHK  = 4'd3;  // free table data check
    localparam logic [3:0] S_SHDN  = 4'd4;  // shift down (remove)
    localparam logic [3:0] S_SHUP  = 4'd5;  // shift up (insert)
    localparam logic [3:0] S_MERGE = 4'd6;  // release merge decision
    localparam logic [3:0] S_OUT   = 4'd7;
    localparam logic [3:0] S_SHDN2 = 4'd8;  // shift down write phase
    localparam logic [3:0] S_SHUP2 = 4'd9;
    localparam logic [3:0] S_URD   = 4'd10; // used entry read wait

    // memories
    logic [15:0] free_start [FREE_SLOTS];
    logic [16:0] free_size  [FREE_SLOTS];
    logic [15:0] used_start [USED_SLOTS];
    logic [16:0] used_size  [USED_SLOTS];
    logic [USED_SLOTS-1:0] r_uvalid;

    logic [3:0]  r_state;
    logic [16:0] r_limit, r_top;
    logic [FW:0] r_fcnt;
    logic        r_op;
    logic [15:0] r_req, r_addr;
    logic [UW:0] r_ui;
    logic [UW-1:0] r_uslot;
    logic [FW:0] r_fi;
    logic [FW-1:0] r_ins;
    logic [15:0] r_fs_q, r_prev_s;
    logic [16:0] r_fz_q, r_prev_z, r_bsize;
    logic        r_has_prev;
    logic [15:0] r_us_q;
    logic [16:0] r_uz_q;
    logic [1:0]  r_st;
    logic [15:0] r_ra, r_gs;
    logic        r_ov;

    // free table read address
    logic [FW-1:0] fra;

    assign s_axis_tready = (r_state == S_IDLE) && !r_ov;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {6'd0, r_gs, r_ra, r_st};
    assign pready = 1'b1;
    assign prdata = {15'd0, r_limit};

    logic [16:0] lim;
    assign lim = (r_limit < 17'(HEAP_BYTES)) ? r_limit : 17'(HEAP_BYTES);
    logic [15:0] hdr_rel;
    assign hdr_rel = r_addr - 16'(HEADER_BYTES);

    always_ff @(posedge i_clk) begin
        r_fs_q <= free_start[fra];
        r_fz_q <= free_size[fra];
        r_us_q <= used_start[r_ui[UW-1:0]];
        r_uz_q <= used_size[r_ui[UW-1:0]];
    end

    always_comb begin
        fra = r_fi[FW-1:0];
        unique case (r_state)
            S_SHDN:  fra = FW'(r_fi + 1'b1);
            S_SHUP:  fra = FW'(r_fi - 1'b1);
            default: fra = r_fi[FW-1:0];
        endcase
    end

    logic [16:0] need;
    assign need = {1'b0, r_req} + HDR;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_limit <= 17'd65536; r_top <= '0;
            r_fcnt <= '0; r_uvalid <= '0; r_ov <= 1'b0;
        end else begin
            if (psel && penable && pwrite && paddr == ffca_pkg::REG_HEAP_LIMIT)
                r_limit <= pwdata[16:0];
            if (r_ov && m_axis_tready) r_ov <= 1'b0;
            unique case (r_state)
                S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
                    r_op <= s_axis_tuser; r_req <= s_axis_tdata[15:0];
                    r_addr <= s_axis_tdata[31:16]; r_ui <= '0; r_fi <= '0;
                    r_has_prev <= 1'b0;
                    if ((s_axis_tuser == ffca_pkg::OP_ALLOC && s_axis_tdata[15:0] == 0) ||
                        (s_axis_tuser == ffca_pkg::OP_RELEASE && s_axis_tdata[31:16] == 0))
                    begin
                        r_st <= ffca_pkg::ST_REJECT; r_ra <= '0; r_gs <= '0;
                        r_state <= S_OUT;
                    end else r_state <= S_USCAN;
                end
                S_USCAN: begin
                    if (r_ui == (UW+1)'(USED_SLOTS)) begin
                        r_st <= (r_op == ffca_pkg::OP_ALLOC) ? ffca_pkg::ST_FULL
                                                             : ffca_pkg::ST_REJECT;
                        r_ra <= '0; r_gs <= '0; r_state <= S_OUT;
                    end else if (r_op == ffca_pkg::OP_ALLOC) begin
                        if (!r_uvalid[r_ui[UW-1:0]]) begin
                            r_uslot <= r_ui[UW-1:0]; r_state <= S_FRD;
                        end else r_ui <= r_ui + 1'b1;
                    end else if (r_uvalid[r_ui[UW-1:0]]) begin
                        r_state <= S_URD;
                    end else r_ui <= r_ui + 1'b1;
                end
                S_URD: begin
                    if (r_us_q == r_addr) begin
                        r_uslot <= r_ui[UW-1:0]; r_bsize <= r_uz_q; r_state <= S_FRD;
                    end else begin
                        r_ui <= r_ui + 1'b1; r_state <= S_USCAN;
                    end
                end
                S_FRD: begin
                    if (r_fi >= r_fcnt) begin
                        if (r_op == ffca_pkg::OP_ALLOC) begin
                            if ({1'b0, r_top} + {1'b0, need} > {1'b0, lim}) begin
                                r_st <= ffca_pkg::ST_NOHEAP; r_ra <= '0; r_gs <= '0;
                                r_state <= S_OUT;
                            end else begin
                                r_top <= r_top + need;
                                used_start[r_uslot] <= 16'(r_top + HDR);
                                used_size[r_uslot] <= {1'b0, r_req};
                                r_uvalid[r_uslot] <= 1'b1;
                                r_st <= ffca_pkg::ST_DONE; r_ra <= 16'(r_top + HDR);
                                r_gs <= r_req; r_state <= S_OUT;
                            end
                        end else r_state <= S_MERGE;
                    end else r_state <= S_FCHK;
                end
                S_FCHK: begin
                    if (r_op == ffca_pkg::OP_ALLOC) begin
                        if (r_fz_q >= {1'b0, r_req}) begin
                            used_start[r_uslot] <= 16'({1'b0, r_fs_q} + HDR);
                            r_uvalid[r_uslot] <= 1'b1;
                            r_st <= ffca_pkg::ST_DONE;
                            r_ra <= 16'({1'b0, r_fs_q} + HDR);
                            if (r_fz_q <= need) begin
                                used_size[r_uslot] <= r_fz_q;
                                r_gs <= r_fz_q[15:0];
                                r_state <= S_SHDN;
                            end else begin
                                used_size[r_uslot] <= {1'b0, r_req};
                                r_gs <= r_req;
                                free_start[r_fi[FW-1:0]] <= 16'({1'b0, r_fs_q} + need);
                                free_size[r_fi[FW-1:0]] <= r_fz_q - need;
                                r_state <= S_OUT;
                            end
                        end else begin
                            r_fi <= r_fi + 1'b1; r_state <= S_FRD;
                        end
                    end else if (r_fs_q > hdr_rel) begin
                        r_state <= S_MERGE;
                    end else begin
                        r_prev_s <= r_fs_q; r_prev_z <= r_fz_q; r_has_prev <= 1'b1;
                        r_fi <= r_fi + 1'b1; r_state <= S_FRD;
                    end
                end
                S_MERGE: begin : mrg
                    logic mp, ms;
                    mp = r_has_prev &&
                         ({1'b0, r_prev_s} + HDR + r_prev_z == {1'b0, hdr_rel});
                    ms = (r_fi < r_fcnt) &&
                         ({1'b0, hdr_rel} + HDR + r_bsize == {1'b0, r_fs_q});
                    r_st <= ffca_pkg::ST_DONE; r_ra <= '0; r_gs <= r_bsize[15:0];
                    if (mp && ms) begin
                        free_size[FW'(r_fi - 1'b1)] <= r_prev_z + HDR + HDR + r_bsize + r_fz_q;
                        r_uvalid[r_uslot] <= 1'b0; r_state <= S_SHDN;
                    end else if (mp) begin
                        free_size[FW'(r_fi - 1'b1)] <= r_prev_z + HDR + r_bsize;
                        r_uvalid[r_uslot] <= 1'b0; r_state <= S_OUT;
                    end else if (ms) begin
                        free_start[r_fi[FW-1:0]] <= hdr_rel;
                        free_size[r_fi[FW-1:0]] <= r_fz_q + HDR + r_bsize;
                        r_uvalid[r_uslot] <= 1'b0; r_state <= S_OUT;
                    end else if (r_fcnt >= (FW+1)'(FREE_SLOTS)) begin
                        r_st <= ffca_pkg::ST_FULL; r_gs <= '0; r_state <= S_OUT;
                    end else begin
                        r_uvalid[r_uslot] <= 1'b0; r_ins <= r_fi[FW-1:0];
                        r_fi <= r_fcnt; r_state <= S_SHUP;
                    end
                end
                // remove entry r_fi: copy r_fi+1 down until the end
                S_SHDN: begin
                    if (r_fi + 1'b1 >= r_fcnt) begin
                        r_fcnt <= r_fcnt - 1'b1; r_state <= S_OUT;
                    end else r_state <= S_SHDN2;
                end
                S_SHDN2: begin
                    free_start[r_fi[FW-1:0]] <= r_fs_q;
                    free_size[r_fi[FW-1:0]] <= r_fz_q;
                    r_fi <= r_fi + 1'b1; r_state <= S_SHDN;
                end
                // insert at r_ins: copy r_fi-1 up until r_fi reaches it
                S_SHUP: begin
                    if (r_fi[FW-1:0] == r_ins || r_fi == 0) begin
                        free_start[r_ins] <= hdr_rel;
                        free_size[r_ins] <= r_bsize;
                        r_fcnt <= r_fcnt + 1'b1; r_state <= S_OUT;
                    end else r_state <= S_SHUP2;
                end
                S_SHUP2: begin
                    free_start[r_fi[FW-1:0]] <= r_fs_q;
                    free_size[r_fi[FW-1:0]] <= r_fz_q;
                    r_fi <= r_fi - 1'b1; r_state <= S_SHUP;
                end
                S_OUT: if (!r_ov) begin
                    r_ov <= 1'b1; r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== src/ffca_checker.sv =====
// Port-level checker for the allocator core.
// Depends on ffca_pkg; bound to first_fit_coalescing_allocator_core.
module ffca_props (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        pready
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat dropped or changed");
    a_noacc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while busy");
    a_fail0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != ffca_pkg::ST_DONE |->
        m_axis_tdata[33:2] == 32'd0)
        else $error("failed result carries data");
    a_rel0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[39:34] == 6'd0)
        else $error("pad bits set");
    a_rdy: assert property (@(posedge i_clk) pready)
        else $error("pready low");
endmodule

bind first_fit_coalescing_allocator_core ffca_props u_ffca_props (.*);

// ===== bench/ffca_checker.sv =====
// Result checker for the first-fit coalescing allocator core.
// Watches the request, result and register buses; depends on ffca_pkg.
module ffca_checker #(
    parameter int HEAP_BYTES   = 65536,
    parameter int HEADER_BYTES = 16,
    parameter int FREE_SLOTS   = 32,
    parameter int USED_SLOTS   = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [31:0] i_req_data,
    input  logic        i_req_op,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [39:0] i_res_data,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [0:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_errors,
    output int          o_pending
);
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] addr;
        logic [15:0] size;
    } t_alloc_result;

    // allocator image
    logic [16:0] limit_reg;
    int          top_bytes;
    int          seg_base [FREE_SLOTS];
    int          seg_len  [FREE_SLOTS];
    int          seg_cnt;
    int          blk_addr [USED_SLOTS];
    int          blk_len  [USED_SLOTS];
    bit          blk_live [USED_SLOTS];

    t_alloc_result awaited_q[$];

    function automatic void seg_drop(int i);
        for (int k = i; k + 1 < seg_cnt; k++) begin
            seg_base[k] = seg_base[k + 1];
            seg_len[k]  = seg_len[k + 1];
        end
        if (seg_cnt > 0) seg_cnt--;
    endfunction

    function automatic t_alloc_result grant_block(int req);
        t_alloc_result r;
        int slot, hdr, grant, lim;
        bit hit;
        r = '{status: ffca_pkg::ST_REJECT, addr: 16'd0, size: 16'd0};
        slot = USED_SLOTS;
        hit = 0;
        hdr = 0;
        grant = 0;
        if (req == 0) return r;
        for (int s = USED_SLOTS - 1; s >= 0; s--)
            if (!blk_live[s]) slot = s;
        if (slot >= USED_SLOTS) begin
            r.status = ffca_pkg::ST_FULL;
            return r;
        end
        for (int i = 0; i < seg_cnt; i++) begin
            if (!hit && seg_len[i] >= req) begin
                hdr = seg_base[i];
                if (seg_len[i] <= req + HEADER_BYTES) begin
                    grant = seg_len[i];
                    seg_drop(i);
                end else begin
                    grant = req;
                    seg_base[i] = hdr + HEADER_BYTES + req;
                    seg_len[i]  = seg_len[i] - HEADER_BYTES - req;
                end
                hit = 1;
            end
        end
        if (!hit) begin
            lim = (int'(limit_reg) < HEAP_BYTES) ? int'(limit_reg) : HEAP_BYTES;
            if (top_bytes + HEADER_BYTES + req > lim) begin
                r.status = ffca_pkg::ST_NOHEAP;
                return r;
            end
            hdr = top_bytes;
            top_bytes += HEADER_BYTES + req;
            grant = req;
        end
        blk_addr[slot] = hdr + HEADER_BYTES;
        blk_len[slot]  = grant;
        blk_live[slot] = 1;
        r.status = ffca_pkg::ST_DONE;
        r.addr   = 16'(hdr + HEADER_BYTES);
        r.size   = 16'(grant);
        return r;
    endfunction

    function automatic t_alloc_result free_block(int addr);
        t_alloc_result r;
        int slot, hdr, len, i;
        bit mp, ms;
        r = '{status: ffca_pkg::ST_REJECT, addr: 16'd0, size: 16'd0};
        slot = USED_SLOTS;
        mp = 0;
        ms = 0;
        if (addr == 0) return r;
        for (int s = USED_SLOTS - 1; s >= 0; s--)
            if (blk_live[s] && blk_addr[s] == addr) slot = s;
        if (slot >= USED_SLOTS) return r;
        hdr = addr - HEADER_BYTES;
        len = blk_len[slot];
        // insert point: first segment above the header
        for (i = 0; i < seg_cnt; i++)
            if (seg_base[i] > hdr) break;
        if (i > 0 && seg_base[i - 1] + HEADER_BYTES + seg_len[i - 1] == hdr) mp = 1;
        if (i < seg_cnt && hdr + HEADER_BYTES + len == seg_base[i]) ms = 1;
        if (mp && ms) begin
            seg_len[i - 1] += 2 * HEADER_BYTES + len + seg_len[i];
            seg_drop(i);
        end else if (mp) begin
            seg_len[i - 1] += HEADER_BYTES + len;
        end else if (ms) begin
            seg_base[i] = hdr;
            seg_len[i] += HEADER_BYTES + len;
        end else begin
            if (seg_cnt >= FREE_SLOTS) begin
                r.status = ffca_pkg::ST_FULL;
                return r;
            end
            for (int k = seg_cnt; k > i; k--) begin
                seg_base[k] = seg_base[k - 1];
                seg_len[k]  = seg_len[k - 1];
            end
            seg_base[i] = hdr;
            seg_len[i]  = len;
            seg_cnt++;
        end
        blk_live[slot] = 0;
        r.status = ffca_pkg::ST_DONE;
        r.size   = 16'(len);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_alloc_result got, want;
        if (!i_rst_n) begin
            limit_reg <= 17'd65536;
            top_bytes = 0;
            seg_cnt = 0;
            for (int s = 0; s < USED_SLOTS; s++) blk_live[s] = 0;
            awaited_q.delete();
            o_errors <= 0;
            o_pending <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready &&
                    i_paddr == ffca_pkg::REG_HEAP_LIMIT)
                limit_reg <= i_pwdata[16:0];
            if (i_res_valid && i_res_ready) begin
                got = '{status: i_res_data[1:0], addr: i_res_data[17:2],
                        size: i_res_data[33:18]};
                if (awaited_q.size() == 0) begin
                    if (o_errors < 10)
                        $display("mismatch: unexpected result beat %h", i_res_data);
                    o_errors <= o_errors + 1;
                end else begin
                    want = awaited_q.pop_front();
                    if (got !== want) begin
                        if (o_errors < 10)
                            $display("mismatch: status %0d/%0d addr %h/%h size %0d/%0d (exp/got)",
                                     want.status, got.status, want.addr, got.addr,
                                     want.size, got.size);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                if (i_req_op == ffca_pkg::OP_ALLOC)
                    awaited_q.push_back(grant_block(int'(i_req_data[15:0])));
                else
                    awaited_q.push_back(free_block(int'(i_req_data[31:16])));
            end
            o_pending <= awaited_q.size();
        end
    end
endmodule

// ===== bench/tb_first_fit_coalescing_allocator_core.sv =====
// Testbench top for the first-fit coalescing allocator core.
// Drives requests and heap_limit writes, gives the verdict; uses ffca_checker, ffca_pkg.
module tb_first_fit_coalescing_allocator_core;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 200;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // request_size[15:0], address[31:16]
    logic        s_axis_tuser = 1'b0; // op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // status[1:0], result_address[17:2], granted_size[33:18]
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [0:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int errors;
    int pending;
    int cycles = 0;
    bit calm = 0;            // no new idle gaps started on either side while set
    int ready_hold = 0;
    logic [15:0] live_addrs[$];  // payload addresses seen in granted beats

    always #5 i_clk = ~i_clk;

    first_fit_coalescing_allocator_core dut (
        .i_clk, .i_rst_n,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    ffca_checker chk (
        .i_clk, .i_rst_n,
        .i_req_valid(s_axis_tvalid), .i_req_ready(s_axis_tready),
        .i_req_data(s_axis_tdata), .i_req_op(s_axis_tuser),
        .i_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready),
        .i_res_data(m_axis_tdata),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .i_pready(pready),
        .o_errors(errors), .o_pending(pending)
    );

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side backpressure; also harvest granted addresses for releases
    always @(posedge i_clk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (calm || $urandom_range(0, 1)) begin
            m_axis_tready <= 1'b1;
            ready_hold <= pick_gap();
        end else begin
            m_axis_tready <= 1'b0;
            ready_hold <= pick_gap();
        end
        if (m_axis_tvalid && m_axis_tready && m_axis_tdata[1:0] == ffca_pkg::ST_DONE
                && m_axis_tdata[17:2] != 16'd0) begin
            live_addrs.push_back(m_axis_tdata[17:2]);
            if (live_addrs.size() > 64) void'(live_addrs.pop_front());
        end
    end

    // one request beat; valid stays high into the next beat when no gap follows
    task automatic send_req(logic op, logic [15:0] size, logic [15:0] addr);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {addr, size};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic alloc_req(logic [15:0] size);
        send_req(ffca_pkg::OP_ALLOC, size, 16'($urandom));
    endtask

    task automatic release_req(logic [15:0] addr);
        send_req(ffca_pkg::OP_RELEASE, 16'($urandom), addr);
    endtask

    // register writes only with the engine drained
    task automatic set_heap_limit(logic [16:0] value);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ffca_pkg::REG_HEAP_LIMIT;
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_req(int alloc_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < alloc_pct) begin
            r = $urandom_range(0, 99);
            if (r < 70)      alloc_req(16'($urandom_range(1, 64)));
            else if (r < 90) alloc_req(16'($urandom_range(65, 2000)));
            else if (r < 95) alloc_req(16'd0);
            else             alloc_req(16'($urandom));
        end else begin
            r = $urandom_range(0, 99);
            if (r < 75 && live_addrs.size() > 0)
                release_req(live_addrs[$urandom_range(0, live_addrs.size() - 1)]);
            else if (r < 85) release_req(16'd0);
            else             release_req(16'($urandom));
        end
    endtask

    initial begin
        logic [16:0] limits[5];
        limits = '{17'd256, 17'd65536, 17'd40000, 17'd0, 17'd65536};
        limits[3] = 17'($urandom_range(256, 65536));
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: rejects, first-fit exact/whole/split takes, merges
        calm = 1;
        alloc_req(16'd0);            // zero size
        release_req(16'd0);          // null release
        release_req(16'hFFFF);       // unknown address
        alloc_req(16'd1);            // payload 16
        alloc_req(16'd100);          // payload 33
        alloc_req(16'd50);           // payload 149
        send_req(ffca_pkg::OP_ALLOC, 16'hFFFF, 16'hFFFF);  // heap growth past limit
        release_req(16'd33);
        alloc_req(16'd100);          // exact fit
        release_req(16'd33);
        alloc_req(16'd90);           // leftover too small: whole segment
        release_req(16'd33);
        alloc_req(16'd20);           // split, remainder kept in place
        release_req(16'd16);         // plain insert
        release_req(16'd33);         // merges both sides
        release_req(16'd149);        // merges with predecessor
        release_req(16'd149);        // double release
        send_req(ffca_pkg::OP_RELEASE, 16'hFFFF, 16'hFFF0);
        calm = 0;

        // random phases across heap_limit settings, alternating fill and drain
        for (int ph = 0; ph < 5; ph++) begin
            if (ph > 0) set_heap_limit(limits[ph]);
            for (int n = 0; n < 96; n++) begin
                calm = (n >= 40 && n < 52);
                random_req(((n / 24) % 2 == 0) ? 85 : 35);
            end
            calm = 0;
        end
        set_heap_limit(17'd65536);

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

// ===== first_fit_coalescing_allocator_core.f =====
src/ffca_pkg.sv
src/first_fit_coalescing_allocator_core.sv
src/ffca_checker.sv
bench/ffca_checker.sv
bench/tb_first_fit_coalescing_allocator_core.sv
